// ===== rtl/core/mrd_pkg.sv =====
// Package for the Modbus RTU response deframer: shared types, request and
// value-kind codes, frame constants and the byte-wide CRC-16/Modbus update.
// Depends on nothing; every other file of the block imports it.
package mrd_pkg;

  localparam int unsigned POS_W     = 9;
  localparam logic [7:0]  EXC_LIMIT = 8'h80;
  localparam logic [15:0] CRC_INIT  = 16'hffff;
  localparam logic [15:0] CRC_POLY  = 16'ha001;

  // Fixed body lengths (including the two CRC bytes)
  localparam logic [POS_W-1:0] LEN_EXCEPTION = 9'd5;
  localparam logic [POS_W-1:0] LEN_WRITE     = 9'd8;
  localparam logic [POS_W-1:0] LEN_OTHER     = 9'd4;
  localparam logic [POS_W-1:0] LEN_READ_BASE = 9'd5;

  // Function codes with a six-byte write response body
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
  localparam logic [7:0] FC_READ_FIRST  = 8'd1;
  localparam logic [7:0] FC_READ_LAST   = 8'd4;

  typedef enum logic [1:0] {
    REQ_OTHER         = 2'd0,
    REQ_SETPOINT_WR   = 2'd1,
    REQ_SETPOINT_RD   = 2'd2,
    REQ_MEASURE_RD    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    VK_NONE     = 2'd0,
    VK_SETPOINT = 2'd1,
    VK_MEASURED = 2'd2
  } value_kind_t;

  typedef struct packed {
    logic [1:0] request_kind;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [POS_W-1:0] frame_length;
    logic             response_ok;
    logic [15:0]      value;
    logic             crc_ok;
    logic [7:0]       exc_code;
    logic             is_exception;
    logic [7:0]       func_code;
    logic [7:0]       slave_address;
  } frame_info_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/mrd_in_reg.sv =====
// Input register of the deframer: holds one received byte and its request
// kind until the frame stage takes it. Depends on mrd_pkg.
module mrd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrd_pkg::rx_item_t in_item,
  output logic              hold_valid,
  input  logic              hold_take,
  output mrd_pkg::rx_item_t hold_item
);
  import mrd_pkg::*;

  logic     valid_r;
  rx_item_t item_r;

  // A new byte may enter whenever the slot is empty or is being drained.
  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/core/mrd_frame.sv =====
// Frame stage of the deframer: tracks the byte position, works out the
// frame length, runs the CRC and registers one result per completed frame.
// Depends on mrd_pkg.
module mrd_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_take,
  input  mrd_pkg::rx_item_t    item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mrd_pkg::frame_info_t res_info,
  output logic [1:0]           res_kind
);
  import mrd_pkg::*;

  logic [POS_W-1:0] pos_r, exp_r;
  logic [15:0]      crc_r;
  logic [7:0]       addr_r, func_r, byte_two_r, crc_lo_r;
  logic [23:0]      vbytes_r;
  logic             res_valid_r;
  frame_info_t      res_info_r;
  logic [1:0]       res_kind_r;

  logic [7:0]       b;
  logic [POS_W-1:0] exp_cur;
  logic [23:0]      vbytes_cur;
  logic             is_body, is_crc_lo, is_last;
  logic [15:0]      rx_crc;
  logic             crc_ok, exc;
  logic [15:0]      value;
  value_kind_t      vkind;
  logic             resp_ok;
  frame_info_t      info_nxt;

  assign b         = item.rx_byte;
  // Only the closing byte of a frame needs the result register to be free.
  assign item_take = item_valid && (!is_last || !res_valid_r || res_ready);

  // Frame length becomes known at the function code, or at the byte count
  // for read responses.
  always_comb begin
    exp_cur = exp_r;
    if (pos_r == 9'd1) begin
      if (b > EXC_LIMIT) begin
        exp_cur = LEN_EXCEPTION;
      end else if (b == FC_WRITE_COIL || b == FC_WRITE_REG ||
                   b == FC_WRITE_COILS || b == FC_WRITE_REGS) begin
        exp_cur = LEN_WRITE;
      end else if (b < FC_READ_FIRST || b > FC_READ_LAST) begin
        exp_cur = LEN_OTHER;
      end
    end else if (pos_r == 9'd2 && exp_r == '0) begin
      exp_cur = LEN_READ_BASE + {1'b0, b};
    end
  end

  always_comb begin
    vbytes_cur = vbytes_r;
    case (pos_r)
      9'd3:    vbytes_cur[23:16] = b;
      9'd4:    vbytes_cur[15:8]  = b;
      9'd5:    vbytes_cur[7:0]   = b;
      default: vbytes_cur = vbytes_r;
    endcase
  end

  assign is_body   = (exp_cur == '0) || (pos_r < exp_cur - 9'd2);
  assign is_crc_lo = !is_body && (pos_r == exp_cur - 9'd2);
  assign is_last   = !is_body && !is_crc_lo;

  assign rx_crc = {b, crc_lo_r};
  assign crc_ok = (rx_crc == crc_r);
  assign exc    = func_r > EXC_LIMIT;

  always_comb begin
    value   = '0;
    vkind   = VK_NONE;
    resp_ok = 1'b0;
    if (crc_ok && !exc) begin
      case (req_kind_t'(item.request_kind))
        REQ_SETPOINT_WR: begin
          value   = vbytes_cur[15:0];
          vkind   = VK_SETPOINT;
          resp_ok = 1'b1;
        end
        REQ_SETPOINT_RD: begin
          value   = vbytes_cur[23:8];
          vkind   = VK_SETPOINT;
          resp_ok = 1'b1;
        end
        REQ_MEASURE_RD: begin
          value   = vbytes_cur[23:8];
          vkind   = VK_MEASURED;
        end
        default: begin
          value   = '0;
          vkind   = VK_NONE;
        end
      endcase
    end
  end

  always_comb begin
    info_nxt.slave_address  = addr_r;
    info_nxt.func_code      = func_r;
    info_nxt.is_exception   = exc;
    info_nxt.exc_code       = exc ? byte_two_r : 8'h00;
    info_nxt.crc_ok         = crc_ok;
    info_nxt.value          = value;
    info_nxt.response_ok    = resp_ok;
    info_nxt.frame_length   = exp_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      exp_r      <= '0;
      crc_r      <= CRC_INIT;
      addr_r     <= '0;
      func_r     <= '0;
      byte_two_r <= '0;
      vbytes_r   <= '0;
      crc_lo_r   <= '0;
    end else if (item_take) begin
      if (is_last) begin
        pos_r      <= '0;
        exp_r      <= '0;
        crc_r      <= CRC_INIT;
        addr_r     <= '0;
        func_r     <= '0;
        byte_two_r <= '0;
        vbytes_r   <= '0;
        crc_lo_r   <= '0;
      end else begin
        pos_r    <= pos_r + 9'd1;
        exp_r    <= exp_cur;
        vbytes_r <= vbytes_cur;
        if (pos_r == 9'd0) begin
          addr_r <= b;
        end
        if (pos_r == 9'd1) begin
          func_r <= b;
        end
        if (pos_r == 9'd2) begin
          byte_two_r <= b;
        end
        if (is_body) begin
          crc_r <= crc16_byte(crc_r, b);
        end else begin
          crc_lo_r <= b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_take && is_last) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && is_last) begin
      res_info_r <= info_nxt;
      res_kind_r <= vkind;
    end
  end

  assign res_valid = res_valid_r;
  assign res_info  = res_info_r;
  assign res_kind  = res_kind_r;

endmodule

// ===== rtl/core/modbus_rtu_response_deframer.sv =====
// Modbus RTU response deframer. One received byte is accepted per clock
// cycle, sustained, as long as results are taken; a byte passes an input
// register and then the frame stage, which registers the result of a frame
// as it takes the last CRC byte. The rate is set by the frame stage, which
// does the position step and the eight-bit CRC-16/Modbus update for a byte
// combinationally. The frame length comes from the function code (and the
// byte count for read responses); the block never resynchronises, so the
// byte after each frame is taken as an address.
// Depends on mrd_pkg, mrd_in_reg and mrd_frame.
module modbus_rtu_response_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] request_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] slave_address, [15:8] func_code, [16] is_exception,
  // [24:17] exc_code, [25] crc_ok, [41:26] value, [42] response_ok,
  // [51:43] frame_length, [55:52] zero
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] value_kind
);
  import mrd_pkg::*;

  rx_item_t    in_item, hold_item;
  logic        hold_valid, hold_take;
  frame_info_t res_info;

  assign in_item.rx_byte      = in_tdata;
  assign in_item.request_kind = in_tuser;

  mrd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_item  (hold_item)
  );

  mrd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (hold_valid),
    .item_take  (hold_take),
    .item       (hold_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_info   (res_info),
    .res_kind   (out_tuser)
  );

  assign out_tdata = {4'h0, res_info};

endmodule

// ===== dv/modbus_rtu_response_deframer_check.sv =====
// Checker for the Modbus RTU response deframer: watches both channels, works out the
// summary of every frame from the accepted byte requests and compares it with the results.
// Depends on mrd_pkg for the channel types, the request codes and the frame constants.
module modbus_rtu_response_deframer_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          pending
);
  import mrd_pkg::*;

  typedef struct packed {
    value_kind_t kind;
    frame_info_t info;
  } frame_summary_t;

  frame_summary_t summaries_q[$];
  int errs;

  // Frame tracking state, as the block should hold it.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] flen;
  logic [15:0]      crc;
  logic [7:0]       addr;
  logic [7:0]       fcode;
  logic [7:0]       byte_two;
  logic [7:0]       crc_lo;
  logic [23:0]      value_bytes;

  // Bit-serial form of the reflected CRC, fed one data bit at a time.
  function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] d);
    logic        fb;
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic clear_frame();
    pos         = '0;
    flen        = '0;
    crc         = CRC_INIT;
    addr        = '0;
    fcode       = '0;
    byte_two    = '0;
    crc_lo      = '0;
    value_bytes = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input req_kind_t k);
    int             p;
    int             n;
    bit             good;
    bit             exc;
    frame_summary_t s;
    p = pos;
    if (p == 0) begin
      addr = b;
    end else if (p == 1) begin
      fcode = b;
      if (b > EXC_LIMIT) begin
        flen = LEN_EXCEPTION;
      end else if (b inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS}) begin
        flen = LEN_WRITE;
      end else if (b < FC_READ_FIRST || b > FC_READ_LAST) begin
        flen = LEN_OTHER;
      end
    end else if (p == 2) begin
      byte_two = b;
      // Read responses only learn their length from the byte count.
      if (flen == '0) flen = LEN_READ_BASE + {1'b0, b};
    end else if (p <= 5) begin
      // Positions 3 to 5 are captured even when they are CRC bytes of a short frame.
      value_bytes[8*(5-p) +: 8] = b;
    end

    n = flen;
    if (n == 0 || p < n - 2) begin
      crc = crc_after(crc, b);
      pos = pos + 9'd1;
    end else if (p == n - 2) begin
      crc_lo = b;
      pos    = pos + 9'd1;
    end else begin
      good = ({b, crc_lo} == crc);
      exc  = (fcode > EXC_LIMIT);
      s    = '0;
      s.info.slave_address  = addr;
      s.info.func_code      = fcode;
      s.info.is_exception   = exc;
      s.info.exc_code       = exc ? byte_two : 8'h00;
      s.info.crc_ok         = good;
      s.info.frame_length   = flen;
      s.kind                = VK_NONE;
      // The request kind counts only as it stands with the last CRC byte.
      if (good && !exc) begin
        case (k)
          REQ_SETPOINT_WR: begin
            s.info.value       = value_bytes[15:0];
            s.kind             = VK_SETPOINT;
            s.info.response_ok = 1'b1;
          end
          REQ_SETPOINT_RD: begin
            s.info.value       = value_bytes[23:8];
            s.kind             = VK_SETPOINT;
            s.info.response_ok = 1'b1;
          end
          REQ_MEASURE_RD: begin
            s.info.value = value_bytes[23:8];
            s.kind       = VK_MEASURED;
          end
          default: begin
          end
        endcase
      end
      summaries_q.push_back(s);
      clear_frame();
    end
  endtask

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errs++;
      if (errs <= 10) begin
        $display("mismatch %0d: %s expected 0x%0h, got 0x%0h", errs, what, want, got);
      end
    end
  endtask

  task automatic check_result();
    frame_summary_t want;
    frame_info_t    got;
    got = out_tdata[51:0];
    if (summaries_q.size() == 0) begin
      errs++;
      if (errs <= 10) begin
        $display("mismatch %0d: result for address 0x%0h with no frame outstanding",
                 errs, got.slave_address);
      end
      return;
    end
    want = summaries_q.pop_front();
    compare_field("slave_address", want.info.slave_address, got.slave_address);
    compare_field("func_code", want.info.func_code, got.func_code);
    compare_field("is_exception", want.info.is_exception, got.is_exception);
    compare_field("exc_code", want.info.exc_code, got.exc_code);
    compare_field("crc_ok", want.info.crc_ok, got.crc_ok);
    compare_field("value", want.info.value, got.value);
    compare_field("response_ok", want.info.response_ok, got.response_ok);
    compare_field("frame_length", want.info.frame_length, got.frame_length);
    compare_field("tdata padding", 0, out_tdata[55:52]);
    compare_field("value_kind", want.kind, out_tuser);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata, req_kind_t'(in_tuser));
      if (out_tvalid && out_tready) check_result();
    end
    pending    <= summaries_q.size();
    mismatches <= errs;
  end

endmodule

// ===== dv/modbus_rtu_response_deframer_test.sv =====
// Top of the deframer testbench: clock, reset, byte request stimulus and result stalls.
// Depends on mrd_pkg, the block itself and modbus_rtu_response_deframer_check.
module modbus_rtu_response_deframer_test;
  import mrd_pkg::*;

  localparam int TARGET_BYTES = 1750;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  int          mismatches;
  int          pending;
  int          bytes_sent = 0;
  int          quiet      = 0;
  bit          steady     = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_response_deframer dut (.*);

  modbus_rtu_response_deframer_check checker_i (.*);

  function automatic req_kind_t random_kind();
    return req_kind_t'(2'($urandom_range(0, 3)));
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input req_kind_t k);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Builds a frame whose length follows from its function code (and the byte count for reads), then sends it.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc,
                            input logic [7:0] count, input bit corrupt,
                            input req_kind_t last_kind);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    int          body_len;
    bit          is_read;
    is_read = (fc >= FC_READ_FIRST && fc <= FC_READ_LAST);
    if (fc > EXC_LIMIT) begin
      body_len = 3;
    end else if (fc inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS}) begin
      body_len = 6;
    end else if (is_read) begin
      body_len = 3 + count;
    end else begin
      body_len = 2;
    end
    frame_bytes.push_back(addr);
    frame_bytes.push_back(fc);
    for (int i = 2; i < body_len; i++) begin
      frame_bytes.push_back((i == 2 && is_read) ? count : 8'($urandom));
    end
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_byte(crc, frame_bytes[i]);
    if (corrupt) crc ^= 16'($urandom_range(1, 65535));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], (i == frame_bytes.size() - 1) ? last_kind : random_kind());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: mostly short stalls, some long ones, and one long hold-off that
  // lets the block fill up while byte requests keep coming.
  initial begin
    int r;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && bytes_sent >= 300) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 90) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int         r;
    int         frames;
    logic [7:0] fc;
    logic [7:0] count;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(8'h00, FC_WRITE_REG, 8'h00, 1'b0, REQ_SETPOINT_WR);
    send_frame(8'hff, 8'hff, 8'h00, 1'b0, REQ_MEASURE_RD);
    // A code of exactly 0x80 is not an exception and takes the shortest body.
    send_frame(8'h5a, EXC_LIMIT, 8'h00, 1'b0, REQ_SETPOINT_RD);
    // Zero byte count: the CRC bytes fall into the captured value positions.
    send_frame(8'h01, 8'd3, 8'h00, 1'b0, REQ_SETPOINT_RD);
    send_frame(8'h7f, FC_READ_LAST, 8'd2, 1'b1, REQ_MEASURE_RD);
    send_frame(8'h33, 8'h00, 8'h00, 1'b0, REQ_OTHER);

    frames = 0;
    while (bytes_sent < TARGET_BYTES) begin
      steady = ($urandom_range(0, 4) == 0);
      if (frames == 100) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r     = $urandom_range(0, 99);
      count = 8'($urandom_range(0, 8));
      if ($urandom_range(0, 24) == 0) count = 8'($urandom_range(9, 254));
      if (frames == 60) count = 8'hff;
      if (r < 35 || frames == 60) begin
        fc = 8'($urandom_range(FC_READ_FIRST, FC_READ_LAST));
      end else if (r < 60) begin
        case ($urandom_range(0, 3))
          0: fc = FC_WRITE_COIL;
          1: fc = FC_WRITE_REG;
          2: fc = FC_WRITE_COILS;
          default: fc = FC_WRITE_REGS;
        endcase
      end else if (r < 75) begin
        fc = 8'($urandom_range(8'h81, 8'hff));
      end else begin
        fc = 8'($urandom_range(0, 255));
      end
      send_frame(8'($urandom), fc, count, $urandom_range(0, 7) == 0, random_kind());
      frames++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
